// ----- rtl/mic_pkg.sv -----
// ----------------------------------------------------------------------------
// mic_pkg
// Shared types, constants and helpers of the masked interrupt controller.
// ----------------------------------------------------------------------------
package mic_pkg;

   // Default number of 32-bit pending / enable words
   localparam int WORD_COUNT_DEFAULT = 8;

   // Widest word number an access can name (up to 32 words)
   localparam int WORD_NUM_W = 5;

   // Register map
   localparam logic [31:0] ENABLE_BASE  = 32'h17E0_1100;
   localparam logic [31:0] PENDING_BASE = 32'h17E0_1200;
   localparam logic [31:0] CAUSE_ADDR_A = 32'h17E0_010C;
   localparam logic [31:0] CAUSE_ADDR_B = 32'h17E0_0118;
   localparam logic [31:0] ACK_ADDR     = 32'h17E0_0110;

   // Cause value when nothing is pending and enabled
   localparam logic [9:0] NO_CAUSE = 10'h3FF;

   // Item kinds
   typedef enum logic [1:0] {
      KIND_ASSERT = 2'd0,
      KIND_READ   = 2'd1,
      KIND_WRITE  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   // Decoded access, handed from the decoder to the core
   typedef struct packed {
      logic                  is_assert;
      logic                  rd_enable;
      logic                  rd_pending;
      logic                  rd_cause;
      logic                  wr_enable;
      logic                  wr_pending;
      logic                  wr_ack;
      logic                  unknown;
      logic [WORD_NUM_W-1:0] word;
   } dec_type;

   // Index of the lowest set bit of a word (0 when the word is zero)
   function automatic logic [4:0] first_bit(input logic [31:0] value);
      logic [4:0] idx;
      idx = '0;
      for (int b = 31; b >= 0; b--) begin
         if (value[b]) begin
            idx = 5'(b);
         end
      end
      return idx;
   endfunction

endpackage

// ----- rtl/masked_interrupt_controller.sv -----
// Each item is accepted into the input register, then executed into the
// result register. Throughput: one item per cycle while rsp_stall is low
// or the result register is empty; the 256-line priority encoder is one pass.
// Reset: synchronous, active high; clears pending and enable words, sets the
// cause to 1023 and drops the request line and both valid flags.
// ----------------------------------------------------------------------------
// masked_interrupt_controller
// Interrupt distributor with pending / enable words, a cause register and a
// request line, driven by interrupt assertions and word bus accesses.
// ----------------------------------------------------------------------------
module masked_interrupt_controller #(
   parameter int WORD_COUNT = mic_pkg::WORD_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_irq_number,
   input  logic [31:0] req_bus_address,
   input  logic [31:0] req_write_data,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic        rsp_unknown_access,
   output logic        rsp_irq_out
);
   import mic_pkg::*;

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [1:0]  kind_ff;
   logic [7:0]  irq_number_ff;
   logic [31:0] bus_address_ff;
   logic [31:0] write_data_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [31:0] read_data_ff;
   logic        unknown_access_ff;
   logic        irq_out_ff;
   logic        advance;
   logic        exec;
   logic        accept;
   dec_type     dec;
   logic [31:0] core_read_data;
   logic        core_unknown;
   logic        core_irq_out;

   // Handshake control
   assign advance      = !out_valid_ff || !rsp_stall;
   assign exec         = in_valid_ff && advance;
   assign req_stall    = in_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = accept || (in_valid_ff && !exec);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff        <= req_kind;
         irq_number_ff  <= req_irq_number;
         bus_address_ff <= req_bus_address;
         write_data_ff  <= req_write_data;
      end
   end

   mic_decode #(
      .WORD_COUNT (WORD_COUNT)
   ) u_decode (
      .kind        (kind_ff),
      .bus_address (bus_address_ff),
      .dec         (dec)
   );

   mic_core #(
      .WORD_COUNT (WORD_COUNT)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .exec           (exec),
      .irq_number     (irq_number_ff),
      .write_data     (write_data_ff),
      .dec            (dec),
      .read_data      (core_read_data),
      .unknown_access (core_unknown),
      .irq_out        (core_irq_out)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         read_data_ff      <= core_read_data;
         unknown_access_ff <= core_unknown;
         irq_out_ff        <= core_irq_out;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_read_data      = read_data_ff;
   assign rsp_unknown_access = unknown_access_ff;
   assign rsp_irq_out        = irq_out_ff;

endmodule

// ----- rtl/mic_decode.sv -----
// ----------------------------------------------------------------------------
// mic_decode
// Address and kind decode of one item into register selects.
// ----------------------------------------------------------------------------
module mic_decode #(
   parameter int WORD_COUNT = mic_pkg::WORD_COUNT_DEFAULT
) (
   input  logic [1:0]       kind,
   input  logic [31:0]      bus_address,
   output mic_pkg::dec_type dec
);
   import mic_pkg::*;

   localparam logic [31:0] SPAN = 32'(4 * WORD_COUNT);

   logic [31:0] en_off;
   logic [31:0] pend_off;
   logic        en_hit;
   logic        pend_hit;
   logic        cause_hit;
   logic        ack_hit;

   // Window checks on the two word ranges
   assign en_off    = bus_address - ENABLE_BASE;
   assign pend_off  = bus_address - PENDING_BASE;
   assign en_hit    = (bus_address >= ENABLE_BASE) && (en_off < SPAN);
   assign pend_hit  = (bus_address >= PENDING_BASE) && (pend_off < SPAN);
   assign cause_hit = (bus_address == CAUSE_ADDR_A) || (bus_address == CAUSE_ADDR_B);
   assign ack_hit   = (bus_address == ACK_ADDR);

   // Qualify by kind; enable range wins over pending range
   always_comb begin
      dec      = '0;
      dec.word = en_hit ? en_off[WORD_NUM_W+1:2] : pend_off[WORD_NUM_W+1:2];
      unique case (kind_type'(kind))
         KIND_ASSERT: begin
            dec.is_assert = 1'b1;
         end
         KIND_READ: begin
            dec.rd_enable  = en_hit;
            dec.rd_pending = !en_hit && pend_hit;
            dec.rd_cause   = !en_hit && !pend_hit && cause_hit;
            dec.unknown    = !en_hit && !pend_hit && !cause_hit;
         end
         KIND_WRITE: begin
            dec.wr_enable  = en_hit;
            dec.wr_pending = !en_hit && pend_hit;
            dec.wr_ack     = !en_hit && !pend_hit && ack_hit;
            dec.unknown    = !en_hit && !pend_hit && !ack_hit;
         end
         KIND_NONE: begin
            dec.word = '0;
         end
         default: begin
            dec = '0;
         end
      endcase
   end

endmodule

// ----- rtl/mic_ffs.sv -----
// ----------------------------------------------------------------------------
// mic_ffs
// Fixed priority encoder: lowest pending and enabled line over all words.
// ----------------------------------------------------------------------------
module mic_ffs #(
   parameter int WORD_COUNT = mic_pkg::WORD_COUNT_DEFAULT
) (
   input  logic [31:0] live [WORD_COUNT],
   output logic        found,
   output logic [9:0]  cause
);
   import mic_pkg::*;

   logic [4:0] bit_idx [WORD_COUNT];
   logic [WORD_COUNT-1:0] any;

   // Per-word lowest bit and nonzero flag
   for (genvar w = 0; w < WORD_COUNT; w++) begin : g_word
      assign bit_idx[w] = first_bit(live[w]);
      assign any[w]     = |live[w];
   end

   // Lowest nonzero word wins
   always_comb begin
      found = 1'b0;
      cause = NO_CAUSE;
      for (int w = WORD_COUNT - 1; w >= 0; w--) begin
         if (any[w]) begin
            found = 1'b1;
            cause = {5'(w), bit_idx[w]};
         end
      end
   end

endmodule

// ----- rtl/mic_core.sv -----
// ----------------------------------------------------------------------------
// mic_core
// Pending / enable words, cause and request line; executes one item.
// ----------------------------------------------------------------------------
module mic_core #(
   parameter int WORD_COUNT = mic_pkg::WORD_COUNT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             exec,
   input  logic [7:0]       irq_number,
   input  logic [31:0]      write_data,
   input  mic_pkg::dec_type dec,
   output logic [31:0]      read_data,
   output logic             unknown_access,
   output logic             irq_out
);
   import mic_pkg::*;

   localparam int IDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

   logic [31:0] pending_ff [WORD_COUNT];
   logic [31:0] pending_in [WORD_COUNT];
   logic [31:0] enable_ff  [WORD_COUNT];
   logic [31:0] enable_in  [WORD_COUNT];
   logic [31:0] live       [WORD_COUNT];
   logic [9:0]  active_cause_ff;
   logic [9:0]  active_cause_in;
   logic        request_level_ff;
   logic        request_level_in;
   logic        ffs_found;
   logic [9:0]  ffs_cause;
   logic        recompute;
   logic [WORD_NUM_W-1:0] assert_word;
   logic [WORD_NUM_W-1:0] ack_word;

   assign assert_word = {2'b00, irq_number[7:5]};
   assign ack_word    = write_data[9:5];

   // Next value of each word
   for (genvar w = 0; w < WORD_COUNT; w++) begin : g_word
      logic [31:0] set_mask;
      logic [31:0] clr_mask;

      assign set_mask = (dec.is_assert && assert_word == WORD_NUM_W'(w))
                        ? (32'd1 << irq_number[4:0]) : '0;
      assign clr_mask = ((dec.wr_ack && ack_word == WORD_NUM_W'(w))
                         ? (32'd1 << write_data[4:0]) : '0)
                      | ((dec.wr_pending && dec.word == WORD_NUM_W'(w))
                         ? write_data : '0);
      assign pending_in[w] = (pending_ff[w] | set_mask) & ~clr_mask;
      assign enable_in[w]  = (dec.wr_enable && dec.word == WORD_NUM_W'(w))
                             ? write_data : enable_ff[w];
      assign live[w]       = pending_in[w] & enable_in[w];
   end

   mic_ffs #(
      .WORD_COUNT (WORD_COUNT)
   ) u_ffs (
      .live  (live),
      .found (ffs_found),
      .cause (ffs_cause)
   );

   // Cause and line recompute on assert, enable/pending write, ack of the cause
   assign recompute = dec.is_assert || dec.wr_enable || dec.wr_pending
                   || (dec.wr_ack && write_data == {22'd0, active_cause_ff});
   assign active_cause_in  = recompute ? ffs_cause : active_cause_ff;
   assign request_level_in = recompute ? ffs_found : request_level_ff;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < WORD_COUNT; w++) begin
            pending_ff[w] <= '0;
            enable_ff[w]  <= '0;
         end
         active_cause_ff  <= NO_CAUSE;
         request_level_ff <= 1'b0;
      end else if (exec) begin
         pending_ff       <= pending_in;
         enable_ff        <= enable_in;
         active_cause_ff  <= active_cause_in;
         request_level_ff <= request_level_in;
      end
   end

   // Read mux, uses state before this item
   always_comb begin
      priority if (dec.rd_enable) begin
         read_data = enable_ff[dec.word[IDX_W-1:0]];
      end else if (dec.rd_pending) begin
         read_data = pending_ff[dec.word[IDX_W-1:0]];
      end else if (dec.rd_cause) begin
         read_data = {22'd0, active_cause_ff};
      end else begin
         read_data = '0;
      end
   end

   assign unknown_access = dec.unknown;
   assign irq_out        = request_level_in;

endmodule

// ----- tb/masked_interrupt_controller_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_interrupt_controller_tb
// Self-checking bench for the interrupt controller. A queue of items, first
// a directed set and then random traffic, feeds a bursty driver. The driver
// updates a behavioral copy of the pending / enable words on every accepted
// item. A monitor with its own stall pattern compares each result with the
// oldest prediction. A watchdog ends the run if traffic stops.
// ----------------------------------------------------------------------------
module masked_interrupt_controller_tb;
   import mic_pkg::*;

   localparam int NWORDS       = WORD_COUNT_DEFAULT;
   localparam int RANDOM_ITEMS = 500;
   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_CYCLES  = 150;
   localparam int HOLD_AFTER   = 120;
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      kind_type    kind;
      logic [7:0]  irq_number;
      logic [31:0] bus_address;
      logic [31:0] write_data;
      bit          ack_cause;   // data is filled in with the live cause at launch
   } irq_item_type;

   typedef struct {
      logic [31:0] read_data;
      logic        unknown_access;
      logic        irq_out;
   } irq_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = '0;
   logic [7:0]  req_irq_number = '0;
   logic [31:0] req_bus_address = '0;
   logic [31:0] req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_read_data;
   logic        rsp_unknown_access;
   logic        rsp_irq_out;

   // Items waiting to be driven, and results still owed by the block
   irq_item_type req_item_q[$];
   irq_rsp_type  due_rsp_q[$];
   irq_item_type cur_item;

   // Behavioral state of the controller
   logic [31:0] model_pending [NWORDS];
   logic [31:0] model_enable  [NWORDS];
   logic [9:0]  model_cause = NO_CAUSE;
   logic        model_level = 1'b0;

   int total_items  = 0;
   int req_accepted = 0;
   int rsp_seen     = 0;
   int fail_count   = 0;
   int n_assert = 0, n_read = 0, n_write = 0, n_ack_hit = 0, n_unknown = 0, n_raised = 0;

   // Driver pacing
   int burst_left = 1;
   int gap_left   = 0;

   // Receiver pacing
   int hold_left   = 0;
   bit hold_done   = 1'b0;
   int stall_mode  = 0;
   int mode_left   = 0;
   int stall_phase = 0;

   int idle_cycles = 0;

   masked_interrupt_controller #(
      .WORD_COUNT(NWORDS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_irq_number     (req_irq_number),
      .req_bus_address    (req_bus_address),
      .req_write_data     (req_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_unknown_access (rsp_unknown_access),
      .rsp_irq_out        (rsp_irq_out)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Lowest line that is both pending and enabled becomes the cause
   function automatic void update_cause();
      logic [31:0] live;
      bit          found;
      found = 1'b0;
      model_cause = NO_CAUSE;
      model_level = 1'b0;
      for (int w = 0; w < NWORDS; w++) begin
         live = model_pending[w] & model_enable[w];
         for (int b = 0; b < 32; b++) begin
            if (!found && live[b]) begin
               model_cause = 10'(w * 32 + b);
               model_level = 1'b1;
               found = 1'b1;
            end
         end
      end
   endfunction

   // Word index of addr inside a block of NWORDS words at base, or -1
   function automatic int word_in_range(logic [31:0] addr, logic [31:0] base);
      logic [31:0] offset;
      offset = addr - base;
      if (addr < base || offset >= 32'(4 * NWORDS)) begin
         return -1;
      end
      return int'(offset >> 2);
   endfunction

   // Apply one item to the state and return the result it produces
   function automatic irq_rsp_type predict_irq_response(irq_item_type it);
      irq_rsp_type r;
      int          k;
      logic [9:0]  id;
      r = '{32'h0, 1'b0, 1'b0};
      case (it.kind)
         KIND_ASSERT: begin
            n_assert++;
            if (int'(it.irq_number >> 5) < NWORDS) begin
               model_pending[it.irq_number >> 5][it.irq_number[4:0]] = 1'b1;
            end
            update_cause();
         end
         KIND_READ: begin
            n_read++;
            if ((k = word_in_range(it.bus_address, ENABLE_BASE)) >= 0) begin
               r.read_data = model_enable[k];
            end else if ((k = word_in_range(it.bus_address, PENDING_BASE)) >= 0) begin
               r.read_data = model_pending[k];
            end else if (it.bus_address == CAUSE_ADDR_A || it.bus_address == CAUSE_ADDR_B) begin
               r.read_data = {22'h0, model_cause};
            end else begin
               r.unknown_access = 1'b1;
            end
         end
         KIND_WRITE: begin
            n_write++;
            if ((k = word_in_range(it.bus_address, ENABLE_BASE)) >= 0) begin
               model_enable[k] = it.write_data;
               update_cause();
            end else if ((k = word_in_range(it.bus_address, PENDING_BASE)) >= 0) begin
               model_pending[k] &= ~it.write_data;
               update_cause();
            end else if (it.bus_address == ACK_ADDR) begin
               id = it.write_data[9:0];
               if (int'(id[9:5]) < NWORDS) begin
                  model_pending[id[9:5]][id[4:0]] = 1'b0;
               end
               // only an acknowledge of the current cause moves the cause
               if (it.write_data == {22'h0, model_cause}) begin
                  n_ack_hit++;
                  update_cause();
               end
            end else begin
               r.unknown_access = 1'b1;
            end
         end
         default: ;
      endcase
      if (r.unknown_access) begin
         n_unknown++;
      end
      r.irq_out = model_level;
      return r;
   endfunction

   function automatic irq_item_type make_item(kind_type kind, logic [7:0] irq_number,
                                              logic [31:0] addr, logic [31:0] data,
                                              bit ack_cause);
      irq_item_type it;
      it.kind        = kind;
      it.irq_number  = irq_number;
      it.bus_address = addr;
      it.write_data  = data;
      it.ack_cause   = ack_cause;
      return it;
   endfunction

   // Some address inside a word range, low byte bits included
   function automatic logic [31:0] range_address(logic [31:0] base);
      return base + 32'(4 * $urandom_range(0, NWORDS - 1) + $urandom_range(0, 3));
   endfunction

   // Addresses at and around the edges of the map, or anywhere
   function automatic logic [31:0] odd_address();
      case ($urandom_range(0, 7))
         0: return ENABLE_BASE - 32'($urandom_range(1, 4));
         1: return PENDING_BASE + 32'(4 * NWORDS + $urandom_range(0, 3));
         2: return ACK_ADDR;
         3: return CAUSE_ADDR_A + 32'($urandom_range(1, 4));
         4: return CAUSE_ADDR_B - 32'($urandom_range(1, 4));
         5: return {16'h17E0, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic irq_item_type random_item();
      irq_item_type it;
      int           pick;
      int           target;
      int           c;
      it = make_item(KIND_ASSERT, 8'($urandom), $urandom, $urandom, 1'b0);
      pick   = $urandom_range(0, 99);
      target = $urandom_range(0, 99);
      c      = $urandom_range(0, 9);
      if (pick < 35) begin
         // concentrate half of the assertions on the low words
         if (c < 5) begin
            it.irq_number = 8'($urandom_range(0, 63));
         end
      end else if (pick < 60) begin
         it.kind = KIND_READ;
         if (target < 30) begin
            it.bus_address = range_address(ENABLE_BASE);
         end else if (target < 55) begin
            it.bus_address = range_address(PENDING_BASE);
         end else if (target < 75) begin
            it.bus_address = (c < 5) ? CAUSE_ADDR_A : CAUSE_ADDR_B;
         end else begin
            it.bus_address = odd_address();
         end
      end else if (pick < 97) begin
         it.kind = KIND_WRITE;
         if (target < 30) begin
            it.bus_address = range_address(ENABLE_BASE);
            case (c)
               5, 6:    it.write_data = '1;
               7:       it.write_data = '0;
               8:       it.write_data = 32'h1 << $urandom_range(0, 31);
               9:       it.write_data = $urandom & $urandom;
               default: it.write_data = $urandom;
            endcase
         end else if (target < 50) begin
            it.bus_address = range_address(PENDING_BASE);
            case (c)
               0, 1, 2: it.write_data = 32'h1 << $urandom_range(0, 31);
               7:       it.write_data = '1;
               8:       it.write_data = '0;
               9:       it.write_data = $urandom;
               default: it.write_data = $urandom & $urandom & $urandom;
            endcase
         end else if (target < 85) begin
            it.bus_address = ACK_ADDR;
            case (c)
               6, 7:    it.write_data = {24'h0, 8'($urandom)};
               8:       it.write_data = $urandom;
               9:       it.write_data = 32'($urandom_range(256, 1023));
               default: it.ack_cause = 1'b1;
            endcase
         end else begin
            it.bus_address = odd_address();
         end
      end else begin
         it.kind = KIND_NONE;
      end
      return it;
   endfunction

   // Driver: bursts of items separated by random gaps
   always @(posedge clock) begin
      logic nxt_valid;
      if (reset) begin
         req_valid <= 1'b0;
         for (int w = 0; w < NWORDS; w++) begin
            model_pending[w] = '0;
            model_enable[w]  = '0;
         end
         model_cause = NO_CAUSE;
         model_level = 1'b0;
      end else begin
         nxt_valid = req_valid;
         if (req_valid && !req_stall) begin
            due_rsp_q.push_back(predict_irq_response(cur_item));
            req_accepted++;
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (req_item_q.size() > 0) begin
               cur_item = req_item_q.pop_front();
               // state already reflects every earlier item here
               if (cur_item.ack_cause) begin
                  cur_item.write_data = {22'h0, model_cause};
               end
               req_kind        <= cur_item.kind;
               req_irq_number  <= cur_item.irq_number;
               req_bus_address <= cur_item.bus_address;
               req_write_data  <= cur_item.write_data;
               nxt_valid = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
               end
            end
         end
         req_valid <= nxt_valid;
      end
   end

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Monitor: check results, then pick the next stall value
   always @(posedge clock) begin
      irq_rsp_type want;
      logic        nxt_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (rsp_irq_out === 1'b1) begin
               n_raised++;
            end
            if (due_rsp_q.size() == 0) begin
               $display("%0t ns: unexpected result, read_data %h unknown %b irq %b",
                        $time, rsp_read_data, rsp_unknown_access, rsp_irq_out);
               fail_count++;
            end else begin
               want = due_rsp_q.pop_front();
               compare_field("rsp_read_data", want.read_data, rsp_read_data);
               compare_field("rsp_unknown_access", 32'(want.unknown_access),
                             32'(rsp_unknown_access));
               compare_field("rsp_irq_out", 32'(want.irq_out), 32'(rsp_irq_out));
            end
         end
         stall_phase++;
         if (hold_left > 0) begin
            hold_left--;
            nxt_stall = 1'b1;
         end else if (!hold_done && rsp_seen >= HOLD_AFTER) begin
            // one long hold-off so the block backs up into its input
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            nxt_stall = 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(16, 80);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0:       nxt_stall = 1'b0;
               1:       nxt_stall = ($urandom_range(0, 99) < 25);
               2:       nxt_stall = ($urandom_range(0, 99) < 70);
               default: nxt_stall = (stall_phase % 3 == 0);
            endcase
         end
         rsp_stall <= nxt_stall;
      end
   end

   // Watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus and end of run
   initial begin
      // reset state, idle reads
      req_item_q.push_back(make_item(KIND_READ, 8'h00, CAUSE_ADDR_A, 32'h0, 1'b0));
      req_item_q.push_back(make_item(KIND_READ, 8'hFF, CAUSE_ADDR_B, 32'hFFFF_FFFF, 1'b0));
      // enable everything in word 0 and only the top line of the last word
      req_item_q.push_back(make_item(KIND_WRITE, 8'h00, ENABLE_BASE, 32'hFFFF_FFFF, 1'b0));
      req_item_q.push_back(make_item(KIND_WRITE, 8'h00, ENABLE_BASE + 32'(4 * NWORDS - 4),
                                     32'h8000_0000, 1'b0));
      // lowest and highest lines
      req_item_q.push_back(make_item(KIND_ASSERT, 8'h00, 32'h0, 32'h0, 1'b0));
      req_item_q.push_back(make_item(KIND_ASSERT, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
      req_item_q.push_back(make_item(KIND_READ, 8'h00, PENDING_BASE + 32'(4 * NWORDS - 4),
                                     32'h0, 1'b0));
      req_item_q.push_back(make_item(KIND_READ, 8'h00, ENABLE_BASE + 32'(4 * NWORDS - 1),
                                     32'h0, 1'b0));
      // acknowledge of a line that is not the cause, then of the cause
      req_item_q.push_back(make_item(KIND_WRITE, 8'h00, ACK_ADDR, 32'd255, 1'b0));
      req_item_q.push_back(make_item(KIND_WRITE, 8'h00, ACK_ADDR, 32'h0, 1'b1));
      req_item_q.push_back(make_item(KIND_ASSERT, 8'd31, 32'h0, 32'h0, 1'b0));
      req_item_q.push_back(make_item(KIND_ASSERT, 8'd5, 32'h0, 32'h0, 1'b0));
      // clear line 5 by pending mask, cause falls back to 31
      req_item_q.push_back(make_item(KIND_WRITE, 8'h00, PENDING_BASE + 32'h1, 32'h20, 1'b0));
      // acknowledge with upper data bits set: clears but leaves cause alone
      req_item_q.push_back(make_item(KIND_WRITE, 8'h00, ACK_ADDR, 32'h0000_041F, 1'b0));
      req_item_q.push_back(make_item(KIND_READ, 8'h00, CAUSE_ADDR_A, 32'h0, 1'b0));
      // acknowledge beyond the implemented lines
      req_item_q.push_back(make_item(KIND_WRITE, 8'h00, ACK_ADDR, 32'd1023, 1'b0));
      req_item_q.push_back(make_item(KIND_WRITE, 8'h00, ENABLE_BASE, 32'h0, 1'b0));
      // acknowledge of 1023 while nothing is live
      req_item_q.push_back(make_item(KIND_WRITE, 8'h00, ACK_ADDR, 32'd1023, 1'b0));
      // addresses that decode to nothing
      req_item_q.push_back(make_item(KIND_READ, 8'h00, ENABLE_BASE - 32'd4, 32'h0, 1'b0));
      req_item_q.push_back(make_item(KIND_WRITE, 8'h00, PENDING_BASE + 32'(4 * NWORDS),
                                     32'hFFFF_FFFF, 1'b0));
      req_item_q.push_back(make_item(KIND_READ, 8'h00, ACK_ADDR, 32'h0, 1'b0));
      req_item_q.push_back(make_item(KIND_WRITE, 8'h00, CAUSE_ADDR_A, 32'h0, 1'b0));
      req_item_q.push_back(make_item(KIND_READ, 8'h00, 32'hFFFF_FFFF, 32'h0, 1'b0));
      req_item_q.push_back(make_item(KIND_WRITE, 8'h00, 32'h0, 32'h0, 1'b0));
      // unused kind
      req_item_q.push_back(make_item(KIND_NONE, 8'hFF, PENDING_BASE, 32'hFFFF_FFFF, 1'b0));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         req_item_q.push_back(random_item());
      end
      total_items = req_item_q.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (req_accepted < total_items || due_rsp_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d items: %0d assertions, %0d reads, %0d writes, %0d unknown accesses",
               req_accepted, n_assert, n_read, n_write, n_unknown);
      $display("%0d acknowledges moved the cause; request line high on %0d of %0d results",
               n_ack_hit, n_raised, rsp_seen);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/mic_pkg.sv
rtl/mic_decode.sv
rtl/mic_ffs.sv
rtl/mic_core.sv
rtl/masked_interrupt_controller.sv
tb/masked_interrupt_controller_tb.sv
